// File: hdl/crc8fr_pkg.sv
`default_nettype none

package crc8fr_pkg;

  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_SYNC_ADDR = 2'd0;

  localparam logic [7:0] SYNC_RESET    = 8'hFF;
  localparam logic [7:0] CRC_PRESET    = 8'hFF;
  localparam logic [7:0] CRC_XOROUT    = 8'hFF;
  localparam logic [7:0] CRC_POLY_REFL = 8'hB2;

  // Update request from the beat sequencer to the running CRC
  typedef struct packed {
    logic       feed;
    logic       restart;
    logic [7:0] data;
  } crc_ctrl_t;

  // One byte through the reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY_REFL;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/crc8fr_crc.sv
`default_nettype none

module crc8fr_crc (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire crc8fr_pkg::crc_ctrl_t ctrl_i,
  output logic [7:0]                 crc_o
);
  import crc8fr_pkg::*;

  logic [7:0] crc_q;
  logic [7:0] crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.restart) begin
      crc_d = CRC_PRESET;
    end else if (ctrl_i.feed) begin
      crc_d = crc8_feed(crc_q, ctrl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_PRESET;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

// File: hdl/crc8_message_framer.sv
`default_nettype none

// Channel   | Dir | Handshake                | Payload
// ----------+-----+--------------------------+--------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready     | tdata: payload_byte, topic_id, generation
//           |     |                          | tlast: last_byte
// m_axis    | out | m_axis_tvalid/tready     | tdata: out_byte; tuser: is_crc
//           |     |                          | tlast: last_of_run
// apb       | in  | psel/penable/pwrite      | register 0 at 0x0: sync_byte
//
// One item emits one output beat per cycle: 1 beat for a mid-frame byte, 2 with the CRC,
// 4 for a frame's first byte and 5 for a single-byte message. Items follow back to back at
// one per cycle while each gives one beat; the single output beat per cycle sets the rate.
// The item slot refills in the cycle its last beat moves to the output register.
// Reset (rst_ni low, asynchronous) closes any open frame, presets the CRC to 0xFF and sets
// sync_byte to 0xFF. A stall on m_axis holds the output beat and backs up into the slot.

module crc8_message_framer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] payload_byte, [15:8] topic_id, [23:16] generation
  input  wire logic [23:0]                   s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i,

  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]                         m_axis_tdata_o,
  // [0] is_crc
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crc8fr_pkg::APB_AW-1:0] paddr,
  input  wire logic [crc8fr_pkg::APB_DW-1:0] pwdata,
  output logic [crc8fr_pkg::APB_DW-1:0]      prdata,
  output logic                               pready
);
  import crc8fr_pkg::*;

  // Beat sequence of one item
  localparam logic [2:0] PH_SYNC = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_GEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  // Configuration
  logic [7:0] sync_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_SYNC_ADDR);
  assign prdata = (paddr == REG_SYNC_ADDR) ? {{(APB_DW-8){1'b0}}, sync_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else if (cfg_wr) begin
      sync_q <= pwdata[7:0];
    end
  end

  // Item slot: holds one accepted item while its beats go out
  logic       slot_valid_q, slot_valid_d;
  logic [2:0] phase_q, phase_d;
  logic       frame_q, frame_d;
  logic [7:0] data_q, id_q, gen_q;
  logic       last_q;

  // Output register
  logic       m_valid_q;
  logic [7:0] m_byte_q;
  logic       m_crc_q;
  logic       m_last_q;

  logic       s_hs;
  logic       out_load;
  logic       emit;
  logic       slot_final;
  logic [7:0] beat_byte;
  logic [7:0] crc_val;
  crc_ctrl_t  crc_ctrl;

  assign s_hs       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load   = !m_valid_q || m_axis_tready_i;
  assign emit       = slot_valid_q && out_load;
  assign slot_final = (phase_q == PH_CRC) || ((phase_q == PH_DATA) && !last_q);

  // Take a new item when the slot is empty or its final beat leaves now
  assign s_axis_tready_o = !slot_valid_q || (emit && slot_final);

  always_comb begin
    unique case (phase_q)
      PH_SYNC: beat_byte = sync_q;
      PH_ID:   beat_byte = id_q;
      PH_GEN:  beat_byte = gen_q;
      PH_DATA: beat_byte = data_q;
      PH_CRC:  beat_byte = crc_val ^ CRC_XOROUT;
      default: beat_byte = 8'h00;
    endcase
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    phase_d      = phase_q;
    frame_d      = frame_q;
    if (s_hs) begin
      // Open a frame with the header beats, else go straight to data
      slot_valid_d = 1'b1;
      phase_d      = frame_q ? PH_DATA : PH_SYNC;
      frame_d      = !s_axis_tlast_i;
    end else if (emit) begin
      if (slot_final) begin
        slot_valid_d = 1'b0;
      end else begin
        phase_d = phase_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
      phase_q      <= PH_SYNC;
      frame_q      <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
      phase_q      <= phase_d;
      frame_q      <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      data_q <= s_axis_tdata_i[7:0];
      id_q   <= s_axis_tdata_i[15:8];
      gen_q  <= s_axis_tdata_i[23:16];
      last_q <= s_axis_tlast_i;
    end
  end

  // Fold every header and data beat into the CRC; preset again once the CRC beat goes out
  assign crc_ctrl.feed    = emit && (phase_q != PH_CRC);
  assign crc_ctrl.restart = emit && (phase_q == PH_CRC);
  assign crc_ctrl.data    = beat_byte;

  crc8fr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_byte_q <= beat_byte;
      m_crc_q  <= (phase_q == PH_CRC);
      m_last_q <= slot_final;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_byte_q;
  assign m_axis_tuser_o  = m_crc_q;
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  a_crc_beat_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("CRC beat without end of run");

  a_crc_phase_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_valid_q && (phase_q == PH_CRC) |-> last_q)
    else $error("CRC phase on an item that does not close the frame");

  a_last_closes_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && s_axis_tlast_i |=> !frame_q)
    else $error("frame left open after last byte");

  a_crc_preset_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_q && !slot_valid_q |-> (crc_val == CRC_PRESET))
    else $error("CRC not preset between frames");

  a_header_only_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && frame_q |=> (phase_q == PH_DATA))
    else $error("header beats inside an open frame");
`endif

endmodule

`default_nettype wire
